// ===== design/line_segment_intersect_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Line/segment intersect assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LINE_SEGMENT_INTERSECT_UNIT_MACROS_SVH
`define LINE_SEGMENT_INTERSECT_UNIT_MACROS_SVH

// same-cycle implication
`define LSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Line/segment intersect package
// Fixed field widths, stream word layout and quotient format.
// ----------------------------------------------------------------------------
package lsi_pkg;

    // field widths on the stream words
    localparam int FieldBits = 32;
    localparam int ConstBits = 64;

    // quotient t: 32 fraction bits, one integer bit for t == 1
    localparam int TFrac = 32;

    // input word layout, lowest bit first
    localparam int AOff   = 0;
    localparam int BOff   = 32;
    localparam int COff   = 64;
    localparam int SxOff  = 128;
    localparam int SyOff  = 160;
    localparam int ExOff  = 192;
    localparam int EyOff  = 224;
    localparam int InDataBits = 256;

    // output word layout
    localparam int PxOff = 0;
    localparam int PyOff = 32;
    localparam int OutDataBits = 64;

endpackage

// ===== design/line_segment_intersect_unit.sv =====
// ----------------------------------------------------------------------------
// Line/segment intersect unit
// Intersects the line a*x + b*y = c with a segment in fixed point.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+-------
//  s_axis   | in  | line_a, line_b, line_c, seg_start_x/y,      | -
//           |     | seg_end_x/y                                 |
//  m_axis   | out | point_x, point_y                            | hit
//
//  One word per cycle in and out while m_axis_tready is high and the skid is
//  empty. An accepted word passes six stages that form the products, sums and
//  magnitudes, 32 stages of a restoring divider that make one quotient bit each,
//  one stage that multiplies the direction by t and the output register that holds the result.
//  i_rst_n is synchronous and active low; it empties every stage.
//  A two-entry output (register plus skid) takes the last stage's word while
//  m_axis stalls; the pipeline and s_axis_tready hold while the skid is full.
//
module line_segment_intersect_unit
    import lsi_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // line_a[31:0], line_b[63:32], line_c[127:64], seg_start_x[159:128],
    // seg_start_y[191:160], seg_end_x[223:192], seg_end_y[255:224]
    input  logic [InDataBits-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // point_x[31:0], point_y[63:32]
    output logic [OutDataBits-1:0] m_axis_tdata,
    // hit[0]
    output logic                   m_axis_tuser
);

    localparam int W   = COORD_WIDTH;
    localparam int W1  = W + 1;          // direction
    localparam int W2  = 2 * W;          // c and a*s products
    localparam int W21 = 2 * W + 1;      // a*d products, sum of a*s
    localparam int MW  = 2 * W + 2;      // den, num and their magnitudes
    localparam int TW  = TFrac + 1;      // t with its integer bit
    localparam int PW  = W + TW;         // |d| * t
    localparam int FW  = W + 2;          // point before truncation

    localparam logic [PW-1:0] CeilAdd = PW'((64'd1 << TFrac) - 64'd1);
    localparam logic [TW-1:0] TOne    = TW'(64'd1 << TFrac);

    // ------------------------------------------------------------------
    // stage payload types
    // ------------------------------------------------------------------
    typedef struct packed {
        logic signed [W-1:0]  a;
        logic signed [W-1:0]  b;
        logic signed [W2-1:0] c;
        logic signed [W-1:0]  sx;
        logic signed [W-1:0]  sy;
        logic signed [W1-1:0] dx;
        logic signed [W1-1:0] dy;
    } t_sa;

    typedef struct packed {
        logic signed [W21-1:0] pad;
        logic signed [W21-1:0] pbd;
        logic signed [W2-1:0]  pas;
        logic signed [W2-1:0]  pbs;
        logic signed [W2-1:0]  c;
        logic signed [W-1:0]   sx;
        logic signed [W-1:0]   sy;
        logic signed [W1-1:0]  dx;
        logic signed [W1-1:0]  dy;
    } t_sb;

    // direction as sign and magnitude, carried to the end
    typedef struct packed {
        logic signed [W-1:0] sx;
        logic signed [W-1:0] sy;
        logic                dxn;
        logic                dyn;
        logic [W-1:0]        dxm;
        logic [W-1:0]        dym;
    } t_geo;

    typedef struct packed {
        logic signed [MW-1:0]  den;
        logic signed [W21-1:0] sums;
        logic signed [W2-1:0]  c;
        t_geo                  geo;
    } t_sc;

    typedef struct packed {
        logic signed [MW-1:0] den;
        logic signed [MW-1:0] num;
        t_geo                 geo;
    } t_sd;

    typedef struct packed {
        logic [MW-1:0] mn;
        logic [MW-1:0] md;
        logic          den_zero;
        logic          sign_ok;
        t_geo          geo;
    } t_se;

    typedef struct packed {
        logic             hit;
        logic             eq;
        logic [MW-1:0]    rem;
        logic [MW-1:0]    md;
        logic [TFrac-1:0] q;
        t_geo             geo;
    } t_div;

    typedef struct packed {
        logic          hit;
        logic [PW-1:0] mx;
        logic [PW-1:0] my;
        t_geo          geo;
    } t_sg;

    typedef struct packed {
        logic                 hit;
        logic [FieldBits-1:0] px;
        logic [FieldBits-1:0] py;
    } t_res;

    // ------------------------------------------------------------------
    // pipeline control: one enable, held off while the skid is full
    // ------------------------------------------------------------------
    logic w_en;
    logic w_take;
    logic w_accept;

    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_g_vld;
    logic r_dv_vld [0:TFrac];
    logic r_out_vld, r_skid_vld;

    t_sa  r_a, n_a;
    t_sb  r_b, n_b;
    t_sc  r_c, n_c;
    t_sd  r_d, n_d;
    t_se  r_e, n_e;
    t_div r_dv [0:TFrac];
    t_div n_dv [0:TFrac];
    t_sg  r_g, n_g;
    t_res r_out, r_skid, n_res;

    assign w_en          = !r_skid_vld;
    assign w_accept      = s_axis_tvalid && w_en;
    assign w_take        = r_out_vld && m_axis_tready;
    assign s_axis_tready = w_en;

    // ------------------------------------------------------------------
    // stage A: unpack, form the direction
    // ------------------------------------------------------------------
    always_comb begin
        n_a.a  = signed'(s_axis_tdata[AOff +: W]);
        n_a.b  = signed'(s_axis_tdata[BOff +: W]);
        n_a.c  = signed'(s_axis_tdata[COff +: W2]);
        n_a.sx = signed'(s_axis_tdata[SxOff +: W]);
        n_a.sy = signed'(s_axis_tdata[SyOff +: W]);
        n_a.dx = W1'(signed'(s_axis_tdata[ExOff +: W])) - W1'(n_a.sx);
        n_a.dy = W1'(signed'(s_axis_tdata[EyOff +: W])) - W1'(n_a.sy);
    end

    // ------------------------------------------------------------------
    // stage B: the four products
    // ------------------------------------------------------------------
    always_comb begin
        n_b.pad = W21'(r_a.a) * W21'(r_a.dx);
        n_b.pbd = W21'(r_a.b) * W21'(r_a.dy);
        n_b.pas = W2'(r_a.a) * W2'(r_a.sx);
        n_b.pbs = W2'(r_a.b) * W2'(r_a.sy);
        n_b.c   = r_a.c;
        n_b.sx  = r_a.sx;
        n_b.sy  = r_a.sy;
        n_b.dx  = r_a.dx;
        n_b.dy  = r_a.dy;
    end

    // ------------------------------------------------------------------
    // stage C: den, sum of the start products, direction magnitudes
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [W1-1:0] ndx;
        logic signed [W1-1:0] ndy;
        ndx         = -r_b.dx;
        ndy         = -r_b.dy;
        n_c.den     = MW'(r_b.pad) + MW'(r_b.pbd);
        n_c.sums    = W21'(r_b.pas) + W21'(r_b.pbs);
        n_c.c       = r_b.c;
        n_c.geo.sx  = r_b.sx;
        n_c.geo.sy  = r_b.sy;
        n_c.geo.dxn = r_b.dx[W1-1];
        n_c.geo.dyn = r_b.dy[W1-1];
        n_c.geo.dxm = r_b.dx[W1-1] ? ndx[W-1:0] : r_b.dx[W-1:0];
        n_c.geo.dym = r_b.dy[W1-1] ? ndy[W-1:0] : r_b.dy[W-1:0];
    end

    // ------------------------------------------------------------------
    // stage D: num = c - (a*sx + b*sy)
    // ------------------------------------------------------------------
    always_comb begin
        n_d.num = MW'(r_c.c) - MW'(r_c.sums);
        n_d.den = r_c.den;
        n_d.geo = r_c.geo;
    end

    // ------------------------------------------------------------------
    // stage E: magnitudes and sign test (t must not be negative)
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [MW-1:0] nn;
        logic signed [MW-1:0] nd;
        nn           = -r_d.num;
        nd           = -r_d.den;
        n_e.mn       = r_d.num[MW-1] ? nn : r_d.num;
        n_e.md       = r_d.den[MW-1] ? nd : r_d.den;
        n_e.den_zero = (r_d.den == '0);
        n_e.sign_ok  = (r_d.num == '0) || (r_d.num[MW-1] == r_d.den[MW-1]);
        n_e.geo      = r_d.geo;
    end

    // ------------------------------------------------------------------
    // stage F: range test t <= 1, load the divider
    // ------------------------------------------------------------------
    always_comb begin
        n_dv[0].hit = !r_e.den_zero && r_e.sign_ok && (r_e.mn <= r_e.md);
        n_dv[0].eq  = (r_e.mn == r_e.md);
        n_dv[0].rem = r_e.mn;
        n_dv[0].md  = r_e.md;
        n_dv[0].q   = '0;
        n_dv[0].geo = r_e.geo;
    end

    // ------------------------------------------------------------------
    // divider: one restoring step, one quotient bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < TFrac; k++) begin : g_div
        logic [MW:0] w_r2;
        logic [MW:0] w_diff;
        assign w_r2   = {r_dv[k].rem, 1'b0};
        assign w_diff = w_r2 - {1'b0, r_dv[k].md};

        always_comb begin
            n_dv[k+1]     = r_dv[k];
            n_dv[k+1].rem = w_diff[MW] ? w_r2[MW-1:0] : w_diff[MW-1:0];
            n_dv[k+1].q   = {r_dv[k].q[TFrac-2:0], !w_diff[MW]};
        end
    end

    // ------------------------------------------------------------------
    // stage G: scale the direction by t
    // ------------------------------------------------------------------
    always_comb begin
        logic [TW-1:0] t;
        t       = r_dv[TFrac].eq ? TOne : {1'b0, r_dv[TFrac].q};
        n_g.hit = r_dv[TFrac].hit;
        n_g.mx  = PW'(r_dv[TFrac].geo.dxm) * PW'(t);
        n_g.my  = PW'(r_dv[TFrac].geo.dym) * PW'(t);
        n_g.geo = r_dv[TFrac].geo;
    end

    // ------------------------------------------------------------------
    // final add: start plus floored offset; zero point on a miss
    // ------------------------------------------------------------------
    always_comb begin
        logic [PW-1:0] sx_sum;
        logic [PW-1:0] sy_sum;
        logic [FW-1:0] fx;
        logic [FW-1:0] fy;
        logic [FW-1:0] px;
        logic [FW-1:0] py;
        // a negative direction floors toward minus infinity: round up the magnitude
        sx_sum = r_g.geo.dxn ? (r_g.mx + CeilAdd) : r_g.mx;
        sy_sum = r_g.geo.dyn ? (r_g.my + CeilAdd) : r_g.my;
        fx     = FW'(sx_sum[PW-1:TFrac]);
        fy     = FW'(sy_sum[PW-1:TFrac]);
        px     = r_g.geo.dxn ? (FW'(r_g.geo.sx) - fx) : (FW'(r_g.geo.sx) + fx);
        py     = r_g.geo.dyn ? (FW'(r_g.geo.sy) - fy) : (FW'(r_g.geo.sy) + fy);
        n_res.hit = r_g.hit;
        n_res.px  = r_g.hit ? FieldBits'(signed'(px[W-1:0])) : '0;
        n_res.py  = r_g.hit ? FieldBits'(signed'(py[W-1:0])) : '0;
    end

    // ------------------------------------------------------------------
    // valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_c_vld    <= 1'b0;
            r_d_vld    <= 1'b0;
            r_e_vld    <= 1'b0;
            r_g_vld    <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
            for (int i = 0; i <= TFrac; i++) begin
                r_dv_vld[i] <= 1'b0;
            end
        end else begin
            if (w_en) begin
                r_a_vld     <= w_accept;
                r_b_vld     <= r_a_vld;
                r_c_vld     <= r_b_vld;
                r_d_vld     <= r_c_vld;
                r_e_vld     <= r_d_vld;
                r_dv_vld[0] <= r_e_vld;
                for (int i = 0; i < TFrac; i++) begin
                    r_dv_vld[i+1] <= r_dv_vld[i];
                end
                r_g_vld     <= r_dv_vld[TFrac];
            end
            // output register drains first, skid refills it
            if (!r_out_vld || w_take) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld  <= w_en && r_g_vld;
                end
            end else if (w_en && r_g_vld) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            r_e <= n_e;
            for (int i = 0; i <= TFrac; i++) begin
                r_dv[i] <= n_dv[i];
            end
            r_g <= n_g;
        end
        if (!r_out_vld || w_take) begin
            r_out <= r_skid_vld ? r_skid : n_res;
        end else if (w_en && r_g_vld) begin
            r_skid <= n_res;
        end
    end

    assign m_axis_tvalid                    = r_out_vld;
    assign m_axis_tuser                     = r_out.hit;
    assign m_axis_tdata[PxOff +: FieldBits] = r_out.px;
    assign m_axis_tdata[PyOff +: FieldBits] = r_out.py;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "line_segment_intersect_unit_macros.svh"

    `LSI_ASSERT_NOW(a_skid_behind_out, r_skid_vld, r_out_vld, "skid full with empty output")
    `LSI_ASSERT_NEXT(a_skid_holds, r_skid_vld && !m_axis_tready, r_skid_vld, "skid word lost")
    `LSI_ASSERT_NOW(a_miss_zero, r_out_vld && !r_out.hit, r_out.px == '0 && r_out.py == '0,
        "miss with nonzero point")
    `LSI_ASSERT_NOW(a_stall_ready, r_skid_vld, !s_axis_tready, "input open while skid full")

endmodule
